/* design/udec_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udec_pkg
// Shared types and constants of the percent decoder.
// ----------------------------------------------------------------------------
package udec_pkg;

  // character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF_HEX  = 8'h66;

  // most result bytes one item can cause
  localparam int RES_MAX = 3;
  // hex digits per escape
  localparam logic [1:0] MAX_DIGITS = 2'd2;

  // default depth of the record queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // configuration port
  localparam int CFG_AW = 3;
  localparam logic CFG_WORD_FIX_RETURN = 1'b0;

  // one front-end record: the result bytes of one item
  typedef struct packed {
    logic [RES_MAX-1:0][7:0] bytes;
    logic [1:0]              last_idx;
    logic                    term;
  } udec_rec_t;

endpackage
`default_nettype wire

/* design/udec_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udec_front
// Accepts input items, tracks escape state and builds one result record.
// ----------------------------------------------------------------------------
module udec_front
  import udec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fix_return_mode,
  input  wire logic        item_valid,
  input  wire logic [7:0]  char_in,
  input  wire logic        end_of_string,
  output      logic        rec_push,
  output      udec_rec_t   rec
);

  logic       in_escape_r, in_escape_nxt;
  logic [7:0] escape_value_r, escape_value_nxt;
  logic [1:0] digit_count_r, digit_count_nxt;
  logic       pending_return_r, pending_return_nxt;
  logic [1:0] cnt;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF_HEX)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // next state and result bytes of one item
  always_comb begin
    logic [7:0] slot [4];
    logic [4:0] hv;
    logic       pr_t;
    slot[0] = '0;
    slot[1] = '0;
    slot[2] = '0;
    slot[3] = '0;
    cnt = '0;
    hv = hex_val(char_in);
    pr_t = pending_return_r;
    in_escape_nxt      = in_escape_r;
    escape_value_nxt   = escape_value_r;
    digit_count_nxt    = digit_count_r;
    pending_return_nxt = pending_return_r;
    if (end_of_string) begin
      // flush held cr, open escape, then terminator
      if (pending_return_r) begin
        slot[cnt] = CH_CR;
        cnt = cnt + 2'd1;
      end
      if (in_escape_r) begin
        slot[cnt] = escape_value_r;
        cnt = cnt + 2'd1;
      end
      slot[cnt] = 8'h00;
      cnt = cnt + 2'd1;
      in_escape_nxt      = 1'b0;
      escape_value_nxt   = '0;
      digit_count_nxt    = '0;
      pending_return_nxt = 1'b0;
    end else if (in_escape_r && (digit_count_r < MAX_DIGITS) && hv[4]) begin
      // another hex digit
      escape_value_nxt = {escape_value_r[3:0], hv[3:0]};
      digit_count_nxt  = digit_count_r + 2'd1;
    end else begin
      // close an open escape
      if (in_escape_r) begin
        if (escape_value_r == CH_CR && fix_return_mode) begin
          if (pr_t) begin
            slot[cnt] = CH_CR;
            cnt = cnt + 2'd1;
          end
          pr_t = 1'b1;
        end else begin
          if (pr_t && escape_value_r != CH_LF) begin
            slot[cnt] = CH_CR;
            cnt = cnt + 2'd1;
          end
          slot[cnt] = escape_value_r;
          cnt = cnt + 2'd1;
          pr_t = 1'b0;
        end
        in_escape_nxt = 1'b0;
      end
      // then the byte itself
      if (char_in == CH_PERCENT) begin
        in_escape_nxt    = 1'b1;
        escape_value_nxt = '0;
        digit_count_nxt  = '0;
      end else begin
        if (pr_t) begin
          slot[cnt] = CH_CR;
          cnt = cnt + 2'd1;
        end
        slot[cnt] = char_in;
        cnt = cnt + 2'd1;
        pr_t = 1'b0;
      end
      pending_return_nxt = pr_t;
    end
    rec.bytes[0] = slot[0];
    rec.bytes[1] = slot[1];
    rec.bytes[2] = slot[2];
    rec.last_idx = cnt - 2'd1;
    rec.term     = end_of_string;
  end

  assign rec_push = item_valid && (cnt != 2'd0);

  // escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_escape_r      <= 1'b0;
      escape_value_r   <= '0;
      digit_count_r    <= '0;
      pending_return_r <= 1'b0;
    end else if (item_valid) begin
      in_escape_r      <= in_escape_nxt;
      escape_value_r   <= escape_value_nxt;
      digit_count_r    <= digit_count_nxt;
      pending_return_r <= pending_return_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/udec_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udec_queue
// Short record queue between front and back end.
// ----------------------------------------------------------------------------
module udec_queue
  import udec_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF  // power of two, at least 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  wire udec_rec_t wr_rec,
  output      logic      full,
  input  wire logic      rd_en,
  output      logic      rd_valid,
  output      udec_rec_t rd_rec
);

  localparam int AW = $clog2(DEPTH);

  udec_rec_t   entry_r [DEPTH];
  logic [AW:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW:0] rd_ptr_r, rd_ptr_nxt;

  assign full     = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign rd_valid = (wr_ptr_r != rd_ptr_r);
  assign rd_rec   = entry_r[rd_ptr_r[AW-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + {{AW{1'b0}}, 1'b1};
  assign rd_ptr_nxt = rd_ptr_r + {{AW{1'b0}}, 1'b1};

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r[AW-1:0]] <= wr_rec;
    end
  end

endmodule
`default_nettype wire

/* design/udec_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udec_back
// Takes records from the queue and hands out their bytes one per transfer.
// ----------------------------------------------------------------------------
module udec_back
  import udec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire udec_rec_t  q_rec,
  output      logic       q_pop,
  output      logic       empty,
  input  wire logic       pop,
  output      logic [7:0] byte_out,
  output      logic       is_terminator
);

  logic      cur_valid_r;
  udec_rec_t cur_r;
  logic [1:0] idx_r, idx_nxt;
  logic       last;

  assign last    = (idx_r == cur_r.last_idx);
  assign q_pop   = q_valid && (!cur_valid_r || (pop && last));
  assign idx_nxt = idx_r + 2'd1;
  assign empty   = !cur_valid_r;

  // byte select from the current record
  always_comb begin
    unique case (idx_r)
      2'd0:    byte_out = cur_r.bytes[0];
      2'd1:    byte_out = cur_r.bytes[1];
      2'd2:    byte_out = cur_r.bytes[2];
      default: byte_out = '0;
    endcase
  end

  assign is_terminator = cur_r.term && last;

  // current record control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (cur_valid_r && pop) begin
      if (last) begin
        cur_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_nxt;
      end
    end
  end

  // current record payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rec;
    end
  end

endmodule
`default_nettype wire

/* design/url_percent_decoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// Percent-escape decoder for a byte stream with a queue interface.
// ----------------------------------------------------------------------------
// One input item (a byte or an end mark) is taken in each cycle while full is
// low; the front end settles escape and held-CR state in that cycle and turns
// the item into a record of zero to three result bytes. The back end hands
// out one result byte per cycle while results wait and pop is high, so an
// item yields one output transfer per result: 0 to 3, where an item that
// only adds a hex digit, opens an escape or holds back a CR yields none.
// The record queue (QUEUE_DEPTH entries) lets input run ahead of the output.
// fix_return_mode sits at byte address 0 and should only change while idle.
module url_percent_decoder_top
  import udec_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              push,
  output      logic              full,
  input  wire logic [7:0]        in_char_in,
  input  wire logic              in_end_of_string,
  // result channel
  output      logic              empty,
  input  wire logic              pop,
  output      logic [7:0]        out_byte_out,
  output      logic              out_is_terminator,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  logic      fix_return_r;
  logic      item_valid;
  logic      rec_push;
  udec_rec_t rec;
  logic      q_valid;
  logic      q_pop;
  udec_rec_t q_rec;
  logic      cfg_hit;

  // configuration register
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[CFG_AW-1] == CFG_WORD_FIX_RETURN);
  assign prdata  = cfg_hit ? {31'b0, fix_return_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_return_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      fix_return_r <= pwdata[0];
    end
  end

  assign item_valid = push && !full;

  udec_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .fix_return_mode (fix_return_r),
    .item_valid      (item_valid),
    .char_in         (in_char_in),
    .end_of_string   (in_end_of_string),
    .rec_push        (rec_push),
    .rec             (rec)
  );

  udec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (rec_push),
    .wr_rec   (rec),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_rec   (q_rec)
  );

  udec_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_rec         (q_rec),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .byte_out      (out_byte_out),
    .is_terminator (out_is_terminator)
  );

endmodule
`default_nettype wire

/* design/udec_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udec_checker
// Port-level checks of the percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module udec_checker
  import udec_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              push,
  input wire logic              full,
  input wire logic [7:0]        in_char_in,
  input wire logic              in_end_of_string,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [7:0]        out_byte_out,
  input wire logic              out_is_terminator,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [CFG_AW-1:0] paddr,
  input wire logic [31:0]       pwdata,
  input wire logic [31:0]       prdata,
  input wire logic              pready
);

  // nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result waiting after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte_out) && $stable(out_is_terminator)))
    else $error("stalled result changed");

  // terminator carries a zero byte
  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_terminator) |-> (out_byte_out == 8'h00))
    else $error("terminator with nonzero byte");

  // a write to the mode register reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr[CFG_AW-1] == CFG_WORD_FIX_RETURN)
    |=> (paddr[CFG_AW-1] != CFG_WORD_FIX_RETURN || prdata[0] == $past(pwdata[0])))
    else $error("mode register readback mismatch");

endmodule

bind url_percent_decoder_top udec_checker u_udec_checker (.*);
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the percent decoder: queued byte stream in, decoded
// bytes out, predicted in step with each accepted transfer.
// ----------------------------------------------------------------------------
module tb;
  import udec_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [CFG_AW-1:0] ADDR_FIX_RETURN = CFG_AW'(4 * int'(CFG_WORD_FIX_RETURN));

  typedef struct {
    logic [7:0] ch;
    logic       eos;
  } enc_item_t;

  typedef struct {
    logic [7:0] b;
    logic       term;
  } dec_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [7:0]        in_char_in = 8'h00;
  logic              in_end_of_string = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [7:0]        out_byte_out;
  logic              out_is_terminator;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = 32'h0;
  logic [31:0]       prdata;
  logic              pready;

  enc_item_t raw_q[$];
  dec_byte_t dec_q[$];

  // decoder state as the bench sees it
  logic       fix_return = 1'b0;
  logic       esc_open = 1'b0;
  logic [7:0] esc_val = 8'h00;
  logic [1:0] esc_digits = 2'd0;
  logic       cr_held = 1'b0;

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  out_cnt = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  bit  calm = 1'b0;

  url_percent_decoder_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_char_in        (in_char_in),
    .in_end_of_string  (in_end_of_string),
    .empty             (empty),
    .pop               (pop),
    .out_byte_out      (out_byte_out),
    .out_is_terminator (out_is_terminator),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // plain ascii hex digit test
  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 4'(c - CH_ZERO);
      return 1'b1;
    end
    if (c >= CH_UA && c <= CH_UF) begin
      v = 4'(c - CH_UA + 8'd10);
      return 1'b1;
    end
    if (c >= CH_LA && c <= CH_LF_HEX) begin
      v = 4'(c - CH_LA + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    return (upper ? CH_UA : CH_LA) + 8'(v) - 8'd10;
  endfunction

  task automatic emit(input logic [7:0] b, input logic term);
    dec_byte_t d;
    d.b = b;
    d.term = term;
    dec_q.push_back(d);
  endtask

  // expected decoded bytes of one accepted item
  task automatic decode_item(input enc_item_t it);
    logic [3:0] nib;
    if (it.eos) begin
      if (cr_held) emit(CH_CR, 1'b0);
      if (esc_open) emit(esc_val, 1'b0);
      emit(8'h00, 1'b1);
      esc_open = 1'b0;
      esc_val = 8'h00;
      esc_digits = 2'd0;
      cr_held = 1'b0;
      return;
    end
    if (esc_open) begin
      if (esc_digits < MAX_DIGITS && hex_nibble(it.ch, nib)) begin
        esc_val = {esc_val[3:0], nib};
        esc_digits = esc_digits + 2'd1;
        return;
      end
      if (esc_val == CH_CR && fix_return) begin
        if (cr_held) emit(CH_CR, 1'b0);
        cr_held = 1'b1;
      end else begin
        if (cr_held && esc_val != CH_LF) emit(CH_CR, 1'b0);
        emit(esc_val, 1'b0);
        cr_held = 1'b0;
      end
      esc_open = 1'b0;
    end
    if (it.ch == CH_PERCENT) begin
      esc_open = 1'b1;
      esc_val = 8'h00;
      esc_digits = 2'd0;
    end else begin
      if (cr_held) emit(CH_CR, 1'b0);
      emit(it.ch, 1'b0);
      cr_held = 1'b0;
    end
  endtask

  task automatic add_char(input logic [7:0] c);
    enc_item_t it;
    it.ch = c;
    it.eos = 1'b0;
    raw_q.push_back(it);
  endtask

  task automatic add_eos();
    enc_item_t it;
    it.ch = 8'($urandom_range(0, 255));
    it.eos = 1'b1;
    raw_q.push_back(it);
  endtask

  task automatic add_str(input string s);
    foreach (s[i]) add_char(s[i]);
  endtask

  task automatic add_escape(input logic [7:0] v);
    add_char(CH_PERCENT);
    add_char(hex_char(v[7:4], 1'($urandom_range(0, 1))));
    add_char(hex_char(v[3:0], 1'($urandom_range(0, 1))));
  endtask

  // one chunk of random encoded text, mostly well formed escapes
  task automatic add_random_chunk();
    case ($urandom_range(0, 11))
      0, 1, 2: add_char(8'($urandom_range(0, 255)));
      3, 4:    add_escape(8'($urandom_range(0, 255)));
      5, 6:    add_escape(CH_CR);
      7:       add_escape(CH_LF);
      8: begin
        // single digit escape
        add_char(CH_PERCENT);
        add_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
      9: begin
        // third hex digit ends the escape
        add_escape(8'($urandom_range(0, 255)));
        add_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
      10:      add_char(CH_PERCENT);
      default: add_eos();
    endcase
  endtask

  task automatic add_random_phase(input int n_items);
    int start;
    start = raw_q.size();
    while (raw_q.size() - start < n_items) add_random_chunk();
  endtask

  // all items sent, all results back, then let the pipeline drain
  task automatic wait_idle();
    do @(posedge clk); while (raw_q.size() != 0 || dec_q.size() != 0 || push);
    repeat (16) @(posedge clk);
  endtask

  // register write: setup then access
  task automatic write_fix_return(input logic v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_FIX_RETURN;
    pwdata <= {31'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    fix_return = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // input driver, one item offered until its transfer
  always @(posedge clk) begin : drv_proc
    bit offered;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      offered = push;
      if (push && !full) begin
        decode_item(raw_q[0]);
        void'(raw_q.pop_front());
        offered = 1'b0;
      end
      if (!offered) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (raw_q.size() > 0) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 14) - 1;
            push <= 1'b0;
          end else begin
            push <= 1'b1;
            in_char_in <= raw_q[0].ch;
            in_end_of_string <= raw_q[0].eos;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor and pop control
  always @(posedge clk) begin : mon_proc
    dec_byte_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        out_cnt++;
        if (dec_q.size() == 0) begin
          $display("%0t: unexpected result, actual byte_out %02h is_terminator %0b",
                   $time, out_byte_out, out_is_terminator);
          err_cnt++;
        end else begin
          want = dec_q.pop_front();
          if (out_byte_out !== want.b) begin
            $display("%0t: byte_out expected %02h actual %02h",
                     $time, want.b, out_byte_out);
            err_cnt++;
          end
          if (out_is_terminator !== want.term) begin
            $display("%0t: is_terminator expected %0b actual %0b",
                     $time, want.term, out_is_terminator);
            err_cnt++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && out_cnt >= 60) begin
        hold_done = 1'b1;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 14) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mode off: extremes, empty escape, escaped cr passes, third digit, flush
    write_fix_return(1'b0);
    add_char(8'h00);
    add_char(8'hFF);
    add_str("%%0D+");
    add_str("%aF7");
    add_str("%");
    add_eos();
    wait_idle();

    // mode on: cr after held cr, then leave a cr held with an escape open
    write_fix_return(1'b1);
    add_str("%0d%0D%");
    wait_idle();

    // mode cleared with cr held, escaped lf drops it
    write_fix_return(1'b0);
    add_str("0Ax");
    wait_idle();

    // end of string with held cr and open escape: three results
    write_fix_return(1'b1);
    add_str("%0D%4");
    add_eos();
    wait_idle();

    // random phases over both settings
    add_random_phase(70);
    wait_idle();
    write_fix_return(1'b0);
    add_random_phase(70);
    wait_idle();
    write_fix_return(1'b1);
    add_random_phase(70);
    wait_idle();

    // last phase runs with no idling
    write_fix_return(1'($urandom_range(0, 1)));
    calm = 1'b1;
    add_random_phase(70);
    add_eos();
    wait_idle();
    repeat (20) @(posedge clk);

    if (err_cnt == 0 && dec_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/udec_pkg.sv
design/udec_front.sv
design/udec_queue.sv
design/udec_back.sv
design/url_percent_decoder_top.sv
design/udec_checker.sv
tb/sv/tb.sv
